// ===== rtl/segi_pkg.sv =====
package segi_pkg;

	localparam int COORD_WIDTH = 16;
	// differences
	localparam int DW = COORD_WIDTH + 1;
	// cross terms, one bit wider than a product
	localparam int PW = 2 * DW + 1;
	// magnitude of a normalized numerator or denominator
	localparam int MW = 2 * DW;
	// dividend width: tn * |delta|
	localparam int NW = MW + DW;
	// quotient bits; the quotient is at most |delta|
	localparam int QW = DW;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// division cell state, one per lane
	typedef struct packed {
		logic [NW-1:0] rem;
		logic [QW-1:0] quo;
	} div_lane_t;

	// context that travels alongside the divider chain
	typedef struct packed {
		logic   valid;
		logic   hit;
		logic [MW-1:0] den;
		coord_t p0x;
		coord_t p0y;
		logic   negx;
		logic   negy;
	} div_ctx_t;

endpackage

// ===== rtl/segi_if.sv =====
interface segi_in_if;
	import segi_pkg::*;
	logic   valid;
	logic   ready;
	coord_t a_start_x;
	coord_t a_start_y;
	coord_t a_end_x;
	coord_t a_end_y;
	coord_t b_start_x;
	coord_t b_start_y;
	coord_t b_end_x;
	coord_t b_end_y;
	modport source(output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, input ready);
	modport sink(input valid, a_start_x, a_start_y, a_end_x, a_end_y,
		b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segi_out_if;
	import segi_pkg::*;
	logic   valid;
	logic   ready;
	logic   hit;
	coord_t cross_x;
	coord_t cross_y;
	modport source(output valid, hit, cross_x, cross_y, input ready);
	modport sink(input valid, hit, cross_x, cross_y, output ready);
endinterface

// ===== rtl/segi_front.sv =====
// differences, cross products, sign normalization and range test
module segi_front import segi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  coord_t    a_start_x,
	input  coord_t    a_start_y,
	input  coord_t    a_end_x,
	input  coord_t    a_end_y,
	input  coord_t    b_start_x,
	input  coord_t    b_start_y,
	input  coord_t    b_end_x,
	input  coord_t    b_end_y,
	output div_ctx_t  ctx,
	output logic [MW-1:0] tn_mag,
	output logic [DW-1:0] mag_x,
	output logic [DW-1:0] mag_y
);

	logic signed [DW-1:0] rx, ry, ux, uy, wx, wy;
	logic signed [DW-1:0] rx_s1, ry_s1, ux_s1, uy_s1, wx_s1, wy_s1;
	logic signed [2*DW-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;
	logic signed [DW-1:0] rx_s2, ry_s2;
	coord_t p0x_s1, p0y_s1, p0x_s2, p0y_s2, p0x_s3, p0y_s3;
	logic signed [PW-1:0] den, sn, tn;
	logic [MW-1:0] dmag, smag, tmag;
	logic sneg, tneg, ok;
	logic [2:0] v_q;
	logic signed [DW-1:0] rx_s3, ry_s3;
	logic ok_s3;
	logic [MW-1:0] den_s3, tn_s3;

	// stage 1: differences
	assign rx = DW'(a_end_x) - DW'(a_start_x);
	assign ry = DW'(a_end_y) - DW'(a_start_y);
	assign ux = DW'(b_end_x) - DW'(b_start_x);
	assign uy = DW'(b_end_y) - DW'(b_start_y);
	assign wx = DW'(a_start_x) - DW'(b_start_x);
	assign wy = DW'(a_start_y) - DW'(b_start_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= rx; ry_s1 <= ry; ux_s1 <= ux; uy_s1 <= uy;
			wx_s1 <= wx; wy_s1 <= wy;
			p0x_s1 <= a_start_x; p0y_s1 <= a_start_y;
			// stage 2: products
			m0_s2 <= rx_s1 * uy_s1; m1_s2 <= ux_s1 * ry_s1;
			m2_s2 <= rx_s1 * wy_s1; m3_s2 <= ry_s1 * wx_s1;
			m4_s2 <= ux_s1 * wy_s1; m5_s2 <= uy_s1 * wx_s1;
			rx_s2 <= rx_s1; ry_s2 <= ry_s1;
			p0x_s2 <= p0x_s1; p0y_s2 <= p0y_s1;
			// stage 3: normalized terms and range test
			ok_s3 <= ok;
			den_s3 <= dmag;
			tn_s3 <= tmag;
			rx_s3 <= rx_s2; ry_s3 <= ry_s2;
			p0x_s3 <= p0x_s2; p0y_s3 <= p0y_s2;
		end
	end

	// cross terms and sign fold so the denominator is positive
	assign den = PW'(m0_s2) - PW'(m1_s2);
	assign sn  = PW'(m2_s2) - PW'(m3_s2);
	assign tn  = PW'(m4_s2) - PW'(m5_s2);
	assign dmag = den[PW-1] ? MW'(-den) : MW'(den);
	assign sneg = (sn[PW-1] ^ den[PW-1]) && (sn != '0);
	assign tneg = (tn[PW-1] ^ den[PW-1]) && (tn != '0);
	assign smag = sn[PW-1] ? MW'(-sn) : MW'(sn);
	assign tmag = tn[PW-1] ? MW'(-tn) : MW'(tn);
	assign ok = (den != '0) && !sneg && !tneg && (smag <= dmag) && (tmag <= dmag);

	assign ctx.valid = v_q[2];
	assign ctx.hit   = ok_s3;
	assign ctx.den   = den_s3;
	assign ctx.p0x   = p0x_s3;
	assign ctx.p0y   = p0y_s3;
	assign ctx.negx  = rx_s3[DW-1];
	assign ctx.negy  = ry_s3[DW-1];
	assign tn_mag = ok_s3 ? tn_s3 : '0;
	assign mag_x  = rx_s3[DW-1] ? DW'(-rx_s3) : rx_s3;
	assign mag_y  = ry_s3[DW-1] ? DW'(-ry_s3) : ry_s3;

endmodule

// ===== rtl/segi_div_cell.sv =====
// one restoring-division step for both lanes, registered
module segi_div_cell import segi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic [$clog2(QW)-1:0] bit_idx,
	input  div_ctx_t  ctx_in,
	input  div_lane_t lx_in,
	input  div_lane_t ly_in,
	output div_ctx_t  ctx_out,
	output div_lane_t lx_out,
	output div_lane_t ly_out
);

	logic [NW:0] dsh;
	div_lane_t lx_nxt, ly_nxt;
	logic vld_q;
	div_ctx_t ctx_q;

	// shifted divisor for this quotient bit
	assign dsh = (NW+1)'(ctx_in.den) << bit_idx;

	always_comb begin
		lx_nxt = lx_in;
		ly_nxt = ly_in;
		if ((NW+1)'(lx_in.rem) >= dsh) begin
			lx_nxt.rem = NW'((NW+1)'(lx_in.rem) - dsh);
			lx_nxt.quo[bit_idx] = 1'b1;
		end
		if ((NW+1)'(ly_in.rem) >= dsh) begin
			ly_nxt.rem = NW'((NW+1)'(ly_in.rem) - dsh);
			ly_nxt.quo[bit_idx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= ctx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q  <= ctx_in;
			lx_out <= lx_nxt;
			ly_out <= ly_nxt;
		end
	end

	always_comb begin
		ctx_out = ctx_q;
		ctx_out.valid = vld_q;
	end

endmodule

// ===== rtl/segment_intersection.sv =====
// segment_intersection: tests whether segment A (a_start..a_end) meets
// segment B (b_start..b_end) and returns the meeting point.
// channels: in_w takes eight signed coordinates, out_w returns hit,
// cross_x and cross_y; both are valid/ready, a word moves when both are high
// throughput: one word per cycle while the receiver takes words
// pipeline, from input accept to output valid: three front stages
// (differences, products, range test), one stage forming tn*|r|, QW
// division cells in a chain (one quotient bit per cell) and the output
// register
// the point is start + trunc(t*(end-start)); no hit gives zeros
// reset clears all valid flags; no words are in flight after it
// when the receiver stalls the whole chain freezes; in_w.ready follows the
// output register (ready when it is empty or being taken), so the pipe
// holds every word and drops none
module segment_intersection import segi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	segi_in_if.sink    in_w,
	segi_out_if.source out_w
);

	logic en;
	div_ctx_t  ctx [QW+2];
	div_lane_t lx [QW+1];
	div_lane_t ly [QW+1];
	logic [MW-1:0] tn_mag;
	logic [DW-1:0] mag_x, mag_y;
	logic vld_q;

	// whole pipe advances unless the output word is held
	assign en = !out_w.valid || out_w.ready;
	assign in_w.ready = en;

	segi_front u_front (
		.clk, .arst_n, .en,
		.in_valid (in_w.valid),
		.a_start_x(in_w.a_start_x), .a_start_y(in_w.a_start_y),
		.a_end_x  (in_w.a_end_x),   .a_end_y  (in_w.a_end_y),
		.b_start_x(in_w.b_start_x), .b_start_y(in_w.b_start_y),
		.b_end_x  (in_w.b_end_x),   .b_end_y  (in_w.b_end_y),
		.ctx      (ctx[0]),
		.tn_mag, .mag_x, .mag_y
	);

	// dividend stage: tn * |delta|
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= ctx[0].valid;
		end
	end

	div_ctx_t ctx_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= ctx[0];
			lx[0] <= '{rem: NW'(tn_mag * mag_x), quo: '0};
			ly[0] <= '{rem: NW'(tn_mag * mag_y), quo: '0};
		end
	end

	always_comb begin
		ctx[1] = ctx_s4;
		ctx[1].valid = vld_q;
	end

	// chain of division cells, most significant quotient bit first
	for (genvar i = 0; i < QW; i++) begin : g_cell
		segi_div_cell u_cell (
			.clk, .arst_n, .en,
			.bit_idx($clog2(QW)'(QW - 1 - i)),
			.ctx_in (ctx[i+1]),
			.lx_in  (lx[i]),
			.ly_in  (ly[i]),
			.ctx_out(ctx[i+2]),
			.lx_out (lx[i+1]),
			.ly_out (ly[i+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_w.valid <= 1'b0;
		end else if (en) begin
			out_w.valid <= ctx[QW+1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_w.hit <= ctx[QW+1].hit;
			if (ctx[QW+1].hit) begin
				out_w.cross_x <= ctx[QW+1].negx ?
					ctx[QW+1].p0x - COORD_WIDTH'(lx[QW].quo) :
					ctx[QW+1].p0x + COORD_WIDTH'(lx[QW].quo);
				out_w.cross_y <= ctx[QW+1].negy ?
					ctx[QW+1].p0y - COORD_WIDTH'(ly[QW].quo) :
					ctx[QW+1].p0y + COORD_WIDTH'(ly[QW].quo);
			end else begin
				out_w.cross_x <= '0;
				out_w.cross_y <= '0;
			end
		end
	end

endmodule

// ===== rtl/segi_checker.sv =====
// port-level checks on the intersection block
module segi_checker import segi_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input logic   hit,
	input coord_t cross_x,
	input coord_t cross_y
);

	// no hit carries a zero point
	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (cross_x == '0 && cross_y == '0))
		else $error("miss with nonzero point");

	// input is taken whenever output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready low with empty output");

	// stalled output holds its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(hit) &&
		$stable(cross_x) && $stable(cross_y)))
		else $error("stalled output changed");

	// ready drops only under a stalled output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("ready low without stall");

endmodule

bind segment_intersection segi_checker u_segi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_w.ready),
	.out_valid(out_w.valid),
	.out_ready(out_w.ready),
	.hit      (out_w.hit),
	.cross_x  (out_w.cross_x),
	.cross_y  (out_w.cross_y)
);
